// ===== design/multi_waveform_sample_generator_macros.svh =====
// assertion macros shared by the sample generator rtl
// no dependencies; included by the files that carry assertions
`ifndef MULTI_WAVEFORM_SAMPLE_GENERATOR_MACROS_SVH
`define MULTI_WAVEFORM_SAMPLE_GENERATOR_MACROS_SVH

// same-cycle implication, off during reset
`define MWSG_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MWSG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mwsg_pkg.sv =====
// types, constants and the sine table function of the sample generator
// no dependencies
`default_nettype none

package mwsg_pkg;

    localparam int PHASE_BITS_DEF       = 32;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [1:0] CFG_WAVE_KIND  = 2'd0;
    localparam logic [1:0] CFG_AMPLITUDE  = 2'd1;
    localparam logic [1:0] CFG_DC_OFFSET  = 2'd2;
    localparam logic [1:0] CFG_PHASE_STEP = 2'd3;

    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SAWTOOTH = 2'd2,
        WAVE_SINE     = 2'd3
    } t_wave_kind;

    typedef struct packed {
        t_wave_kind  wave_kind;
        logic [14:0] amplitude;
        logic [14:0] dc_offset;
    } t_cfg;

    typedef struct packed {
        logic [31:0] frac;
        logic        cycle_start;
    } t_word;

    typedef struct packed {
        logic full;
        logic avail;
    } t_q_stat;

    // q15 sine of a 32-bit phase, degree-9 odd polynomial on the folded quarter wave
    function automatic logic signed [16:0] fixed_sine(input logic [31:0] u);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] r;
        logic [63:0] y;
        logic [63:0] mag;
        logic [16:0] mag17;
        z = {34'd0, u[29:0]};
        if (u[30]) begin
            z = 64'd1073741824 - z;
        end
        z2 = (z * z) >> 30;
        r = 64'd5026995 - ((64'd172272 * z2) >> 30);
        r = 64'd85569306 - ((r * z2) >> 30);
        r = 64'd693598668 - ((r * z2) >> 30);
        r = 64'd1686629713 - ((r * z2) >> 30);
        y = (r * z) >> 30;
        mag = (y + 64'd16384) >> 15;
        if (mag > 64'd32768) begin
            mag = 64'd32768;
        end
        mag17 = mag[16:0];
        return u[31] ? -$signed(mag17) : $signed(mag17);
    endfunction

endpackage

`default_nettype wire

// ===== design/mwsg_in_if.sv =====
// request channel: valid, ready and the tick word
// no dependencies
`default_nettype none

interface mwsg_in_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

`default_nettype wire

// ===== design/mwsg_out_if.sv =====
// sample channel: valid, ready, sample code and cycle start flag
// no dependencies
`default_nettype none

interface mwsg_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        cycle_start;

    modport source (output valid, output sample, output cycle_start, input ready);
    modport sink (input valid, input sample, input cycle_start, output ready);
endinterface

`default_nettype wire

// ===== design/mwsg_front.sv =====
// front end: takes tick words, keeps the phase accumulator, pushes phase words
// depends on mwsg_pkg, mwsg_in_if and the macros header
`default_nettype none
`include "multi_waveform_sample_generator_macros.svh"

module mwsg_front #(
    parameter int PHASE_BITS = mwsg_pkg::PHASE_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    mwsg_in_if.sink              i_in,
    input  wire logic [31:0]     i_phase_step,
    input  mwsg_pkg::t_q_stat    i_q_stat,
    output logic                 o_push,
    output mwsg_pkg::t_word      o_word
);

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS:0]   sum;
    logic                  accept;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        sum = {1'b0, r_phase} + {1'b0, PHASE_BITS'(i_phase_step)};
        n_phase = (accept && i_in.tick) ? sum[PHASE_BITS-1:0] : r_phase;
        // top 32 bits of the phase fraction, zero padded below
        o_word.frac        = 32'({r_phase, 32'd0} >> PHASE_BITS);
        o_word.cycle_start = i_in.tick && sum[PHASE_BITS];
        o_push             = accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    `MWSG_ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n, accept && !i_in.tick, $stable(r_phase), "phase moved without tick")

endmodule

`default_nettype wire

// ===== design/mwsg_queue.sv =====
// short queue of phase words between front and back end
// depends on mwsg_pkg
`default_nettype none

module mwsg_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  mwsg_pkg::t_word    i_word,
    input  wire logic          i_pop,
    output mwsg_pkg::t_word    o_word,
    output mwsg_pkg::t_q_stat  o_stat
);

    localparam int DEPTH = mwsg_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mwsg_pkg::t_word  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_word       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.avail = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/mwsg_back.sv =====
// back end: waveform pipeline from phase word to saturated sample
// depends on mwsg_pkg, mwsg_out_if and the macros header
`default_nettype none
`include "multi_waveform_sample_generator_macros.svh"

module mwsg_back #(
    parameter int SINE_TABLE_DEPTH = mwsg_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS      = mwsg_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  mwsg_pkg::t_cfg     i_cfg,
    input  mwsg_pkg::t_word    i_word,
    input  mwsg_pkg::t_q_stat  i_q_stat,
    output logic               o_pop,
    mwsg_out_if.source         o_out
);

    localparam int IDX_W = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
    localparam logic [19:0] SAT_MAX = 20'((1 << SAMPLE_BITS) - 1);

    typedef logic signed [16:0] t_sine_rom [SINE_TABLE_DEPTH];

    function automatic t_sine_rom f_build_rom();
        t_sine_rom t;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            t[k] = mwsg_pkg::fixed_sine(32'((64'(k) << 32) / SINE_TABLE_DEPTH));
        end
        return t;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_rom();

    logic                en;
    logic [2:0]          r_vld;
    logic                r_out_valid;
    logic [15:0]         r_sample;
    logic                r_out_cs;

    logic [48:0]         r1_p;
    logic [IDX_W-1:0]    r1_idx;
    logic                r1_h;
    logic                r1_cs;

    logic signed [16:0]  r2_sine;
    logic [18:0]         r2_lin;
    logic                r2_cs;

    logic signed [32:0]  r3_prod;
    logic [18:0]         r3_lin;
    logic                r3_cs;

    logic [63:0]         idx_prod;
    logic [18:0]         n_lin;
    logic signed [34:0]  sine_sum;
    logic [19:0]         val;
    logic [15:0]         n_sample;

    assign en    = !r_out_valid || o_out.ready;
    assign o_pop = en && i_q_stat.avail;

    assign o_out.valid       = r_out_valid;
    assign o_out.sample      = r_sample;
    assign o_out.cycle_start = r_out_cs;

    assign idx_prod = 64'(i_word.frac) * 64'(SINE_TABLE_DEPTH);

    always_comb begin
        logic [18:0] a19;
        logic [18:0] o19;
        logic [18:0] p_hi;
        logic [18:0] saw;
        logic        nz;
        a19  = 19'(i_cfg.amplitude);
        o19  = 19'(i_cfg.dc_offset);
        p_hi = 19'(r1_p[48:32]);
        saw  = 19'(r1_p[48:33]);
        nz   = |r1_p[31:0];
        case (i_cfg.wave_kind)
            mwsg_pkg::WAVE_SQUARE:   n_lin = r1_h ? o19 : o19 + (a19 << 1);
            mwsg_pkg::WAVE_TRIANGLE: n_lin = r1_h ? o19 + (a19 << 2) - p_hi - 19'(nz)
                                                  : o19 + p_hi;
            mwsg_pkg::WAVE_SAWTOOTH: n_lin = o19 + saw;
            default:                 n_lin = '0;
        endcase
    end

    always_comb begin
        sine_sum = 35'(r3_prod) + $signed({4'd0, i_cfg.dc_offset, 16'd0});
        if (i_cfg.wave_kind == mwsg_pkg::WAVE_SINE) begin
            val = sine_sum[34] ? '0 : 20'(sine_sum[34:15]);
        end else begin
            val = 20'(r3_lin);
        end
        n_sample = (val > SAT_MAX) ? 16'(SAT_MAX) : 16'(val);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p     <= 49'({i_cfg.amplitude, 2'b00}) * 49'(i_word.frac);
            r1_idx   <= idx_prod[32 +: IDX_W];
            r1_h     <= i_word.frac[31];
            r1_cs    <= i_word.cycle_start;
            r2_sine  <= SINE_ROM[r1_idx];
            r2_lin   <= n_lin;
            r2_cs    <= r1_cs;
            r3_prod  <= $signed({1'b0, i_cfg.amplitude}) * r2_sine;
            r3_lin   <= r2_lin;
            r3_cs    <= r2_cs;
            r_sample <= n_sample;
            r_out_cs <= r3_cs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[1:0], o_pop};
            r_out_valid <= r_vld[2];
        end
    end

    `MWSG_ASSERT_IMPL(a_sat_limit, i_clk, i_rst_n, r_out_valid, 20'(r_sample) <= SAT_MAX, "sample above saturation limit")
    `MWSG_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !en, $stable(r_vld), "pipeline moved while stalled")
    `MWSG_ASSERT_IMPL(a_out_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_vld[2]), "result without last stage word")

endmodule

`default_nettype wire

// ===== design/multi_waveform_sample_generator.sv =====
// throughput: one sample per clock while the output is taken; a 2-entry queue
// decouples the phase front end from the 4-stage waveform pipeline, which stalls
// as a whole when the output is held
// the sine lookup is a constant rom with a registered read inside the pipeline
// reset (synchronous, active low) clears phase, registers, queue and stage valids
// depends on mwsg_pkg, mwsg_in_if, mwsg_out_if, mwsg_front, mwsg_queue, mwsg_back
`default_nettype none

module multi_waveform_sample_generator #(
    parameter int PHASE_BITS       = mwsg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = mwsg_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS      = mwsg_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    mwsg_in_if.sink          i_in,
    mwsg_out_if.source       o_out
);

    mwsg_pkg::t_wave_kind r_wave_kind;
    logic [14:0]          r_amplitude;
    logic [14:0]          r_dc_offset;
    logic [31:0]          r_phase_step;

    mwsg_pkg::t_cfg       cfg;
    mwsg_pkg::t_q_stat    q_stat;
    mwsg_pkg::t_word      push_word;
    mwsg_pkg::t_word      head_word;
    logic                 push;
    logic                 pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_kind  <= mwsg_pkg::WAVE_SQUARE;
            r_amplitude  <= '0;
            r_dc_offset  <= '0;
            r_phase_step <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mwsg_pkg::CFG_WAVE_KIND:  r_wave_kind  <= mwsg_pkg::t_wave_kind'(i_cfg_data[1:0]);
                mwsg_pkg::CFG_AMPLITUDE:  r_amplitude  <= i_cfg_data[14:0];
                mwsg_pkg::CFG_DC_OFFSET:  r_dc_offset  <= i_cfg_data[14:0];
                mwsg_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                default:                  r_phase_step <= r_phase_step;
            endcase
        end
    end

    assign cfg.wave_kind = r_wave_kind;
    assign cfg.amplitude = r_amplitude;
    assign cfg.dc_offset = r_dc_offset;

    mwsg_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_phase_step (r_phase_step),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_word       (push_word)
    );

    mwsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (pop),
        .o_word  (head_word),
        .o_stat  (q_stat)
    );

    mwsg_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_word   (head_word),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== verif/tb_multi_waveform_sample_generator.sv =====
// self-checking bench for the dds sample generator: tick words in, sample words out
// predicts each sample from its own phase accumulator, waveform math and sine table
// depends on mwsg_pkg, mwsg_in_if, mwsg_out_if and multi_waveform_sample_generator
`default_nettype none

module tb_multi_waveform_sample_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import mwsg_pkg::*;

    typedef struct packed {
        logic [15:0] sample;
        logic        cycle_start;
    } t_expected_word;

    class dds_sample_checker;
        t_wave_kind      wave;
        logic [14:0]     amp;
        logic [14:0]     offs;
        logic [31:0]     step;
        logic [31:0]     phase;
        int              sine_rom[1024];
        t_expected_word  pending_samples[$];
        int              mismatches;

        function new();
            for (int k = 0; k < 1024; k++) begin
                sine_rom[k] = sine_q15(32'(k) << 22);
            end
            wave       = WAVE_SQUARE;
            amp        = '0;
            offs       = '0;
            step       = '0;
            phase      = '0;
            mismatches = 0;
        endfunction

        // odd polynomial on the folded quarter wave, q30 rounded to q15
        static function int sine_q15(input logic [31:0] u);
            longint unsigned z;
            longint unsigned z2;
            longint unsigned r;
            longint unsigned y;
            longint unsigned mag;
            z = 64'(u[29:0]);
            if (u[30]) begin
                z = 64'd1073741824 - z;
            end
            z2  = (z * z) >> 30;
            r   = 64'd5026995 - ((64'd172272 * z2) >> 30);
            r   = 64'd85569306 - ((r * z2) >> 30);
            r   = 64'd693598668 - ((r * z2) >> 30);
            r   = 64'd1686629713 - ((r * z2) >> 30);
            y   = (r * z) >> 30;
            mag = (y + 64'd16384) >> 15;
            if (mag > 64'd32768) begin
                mag = 64'd32768;
            end
            return u[31] ? -int'(mag) : int'(mag);
        endfunction

        function void apply_cfg(input logic [1:0] idx, input logic [31:0] data);
            case (idx)
                CFG_WAVE_KIND: wave = t_wave_kind'(data[1:0]);
                CFG_AMPLITUDE: amp = data[14:0];
                CFG_DC_OFFSET: offs = data[14:0];
                default: step = data;
            endcase
        endfunction

        function int outstanding();
            return pending_samples.size();
        endfunction

        function void note_tick(input logic tick);
            longint unsigned a;
            longint unsigned o;
            longint unsigned f;
            longint unsigned level;
            longint          acc;
            logic [32:0]     next;
            t_expected_word  word;
            a = 64'(amp);
            o = 64'(offs);
            f = 64'(phase);
            case (wave)
                WAVE_SQUARE: level = phase[31] ? o : o + 2 * a;
                WAVE_TRIANGLE: begin
                    if (!phase[31]) begin
                        level = o + ((4 * a * f) >> 32);
                    end else begin
                        level = o + 2 * a
                                - ((4 * a * (f - 64'h8000_0000) + 64'hFFFF_FFFF) >> 32);
                    end
                end
                WAVE_SAWTOOTH: level = o + ((2 * a * f) >> 32);
                default: begin
                    acc = longint'(a) * longint'(sine_rom[phase[31:22]])
                          + longint'(2 * o) * 64'sd32768;
                    level = (acc < 0) ? 64'd0 : ($unsigned(acc) >> 15);
                end
            endcase
            if (level > 64'd65535) begin
                level = 64'd65535;
            end
            word.sample      = level[15:0];
            word.cycle_start = 1'b0;
            if (tick) begin
                next             = {1'b0, phase} + {1'b0, step};
                word.cycle_start = next[32];
                phase            = next[31:0];
            end
            pending_samples.push_back(word);
        endfunction

        function void check_sample(input logic [15:0] sample, input logic cycle_start);
            t_expected_word word;
            if (pending_samples.size() == 0) begin
                $error("unexpected sample word: sample %0d cycle_start %0b",
                       sample, cycle_start);
                mismatches++;
                return;
            end
            word = pending_samples.pop_front();
            if (sample !== word.sample) begin
                $error("sample: expected %0d, actual %0d", word.sample, sample);
                mismatches++;
            end
            if (cycle_start !== word.cycle_start) begin
                $error("cycle_start: expected %0b, actual %0b",
                       word.cycle_start, cycle_start);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    mwsg_in_if  tick_ch ();
    mwsg_out_if sample_ch ();

    dds_sample_checker samples = new();

    bit quiet_tail;
    bit hold_out_req;
    int sent_count;

    multi_waveform_sample_generator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_ch),
        .o_out      (sample_ch)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && tick_ch.valid && tick_ch.ready) begin
            samples.note_tick(tick_ch.tick);
        end
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            samples.check_sample(sample_ch.sample, sample_ch.cycle_start);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        samples.apply_cfg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // junk above a register's width must be dropped by the block
    task automatic set_regs(input logic [1:0] kind, input logic [14:0] amp,
                            input logic [14:0] offs, input logic [31:0] step,
                            input bit junk);
        logic [31:0] noise;
        noise = junk ? $urandom() : 32'd0;
        write_reg(CFG_WAVE_KIND, {noise[31:2], kind});
        write_reg(CFG_AMPLITUDE, {noise[31:15], amp});
        write_reg(CFG_DC_OFFSET, {noise[16:0], offs});
        write_reg(CFG_PHASE_STEP, step);
    endtask

    task automatic push_tick(input logic tick, input bit with_gaps);
        if (with_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.tick  <= tick;
        do @(posedge i_clk); while (!tick_ch.ready);
        sent_count++;
    endtask

    task automatic drain();
        do @(posedge i_clk); while (samples.outstanding() != 0);
    endtask

    function automatic logic [31:0] pick_level(input logic [31:0] top);
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return top;
            2: return 32'($urandom_range(0, 15));
            3: return top - 32'($urandom_range(0, 15));
            default: return $urandom_range(top, 0);
        endcase
    endfunction

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        sample_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_out_req && !held) begin
                sample_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                held = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                sample_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                sample_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int phase_no;
        int phase_len;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_WAVE_KIND;
        i_cfg_data      <= '0;
        tick_ch.valid   <= 1'b0;
        tick_ch.tick    <= 1'b0;
        quiet_tail   = 1'b0;
        hold_out_req = 1'b0;
        sent_count   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, then each waveform at the quarter points with saturation
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        tick_ch.valid <= 1'b0;
        drain();
        for (int k = 0; k < 4; k++) begin
            // sine with zero offset drives the negative half below zero
            set_regs(2'(k), 15'h7FFF, (k == WAVE_SINE) ? 15'd0 : 15'h7FFF,
                     32'h4000_0000, 1'b1);
            repeat (5) push_tick(1'b1, 1'b0);
            push_tick(1'b0, 1'b0);
            tick_ch.valid <= 1'b0;
            drain();
        end

        phase_no = 0;
        while (sent_count < 2000) begin
            set_regs(2'(pick_level(32'd3)), 15'(pick_level(32'h7FFF)),
                     15'(pick_level(32'h7FFF)), pick_level(32'hFFFF_FFFF),
                     1'($urandom_range(0, 1)));
            phase_len = $urandom_range(20, 150);
            if (phase_no == 2) begin
                hold_out_req = 1'b1;
                phase_len    = 80;
            end
            if (sent_count >= 1700) begin
                quiet_tail = 1'b1;
            end
            repeat (phase_len) push_tick(1'($urandom_range(0, 1)), 1'b1);
            tick_ch.valid <= 1'b0;
            drain();
            phase_no++;
        end

        repeat (8) @(posedge i_clk);
        if (samples.mismatches == 0 && samples.outstanding() == 0) begin
            $display("multi_waveform_sample_generator test passed");
        end else begin
            $display("multi_waveform_sample_generator test failed");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("multi_waveform_sample_generator test failed");
        $finish;
    end

endmodule

`default_nettype wire
